/* sv/uer_pkg.sv */
package uer_pkg;

  localparam int unsigned PINGS_PER_RUN = 5;

  localparam int unsigned TRIG_W  = 10;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned PING_W  = 3;
  localparam int unsigned SUM_W   = 19;
  localparam int unsigned DIST_W  = 15;

  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [TRIG_W-1:0] TRIG_WIDTH_RST = 10'd20;
  localparam logic [CNT_W-1:0]  TIMEOUT_RST    = 17'd100000;
  localparam logic [CNT_W-1:0]  GAP_RST        = 17'd10000;

  typedef enum logic [1:0] {
    REG_TRIG_WIDTH = 2'd0,
    REG_TIMEOUT    = 2'd1,
    REG_GAP        = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TRIG = 3'd1,
    PH_WAIT = 3'd2,
    PH_ECHO = 3'd3,
    PH_GAP  = 3'd4
  } phase_t;

  // distance = round(sum * 32 / (pings * 117)), by reciprocal multiply
  localparam int unsigned     DIST_DIV   = PINGS_PER_RUN * 117;
  localparam int unsigned     DIST_SHIFT = 35;
  localparam longint unsigned DIST_MUL_L =
    ((64'd1 << DIST_SHIFT) + DIST_DIV - 1) / DIST_DIV;
  localparam logic [29:0]     DIST_MUL   = 30'(DIST_MUL_L);

  function automatic logic [DIST_W-1:0] dist_calc(input logic [SUM_W-1:0] sum);
    logic [24:0] m;
    logic [54:0] prod;
    logic [19:0] q;
    m    = 25'({sum, 5'b0}) + 25'(DIST_DIV / 2);
    prod = 55'(m) * 55'(DIST_MUL);
    q    = prod[54:35];
    if (q > 20'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return q[DIST_W-1:0];
  endfunction

endpackage

/* sv/ultrasonic_echo_ranger.sv */
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall  | start_request, echo_level
// out_    | output    | out_valid / out_stall| trigger_level, busy_res, done_res,
//         |           |                      | timed_out, distance_q4
// cfg     | input     | apb psel/penable     | trigger width, echo timeout, gap
//
// one word in, one word out; taken every cycle in_stall is low, result next cycle
// the clock period is set by one pass of the phase logic plus the distance multiply
// in_stall rises only while a result waits and out_stall is high
// rst_n is synchronous: phase idle, counters and distance zero, registers at defaults
module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_start_request,
  input  logic              in_echo_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_trigger_level,
  output logic              out_busy_res,
  output logic              out_done_res,
  output logic              out_timed_out,
  output logic [DIST_W-1:0] out_distance_q4,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [TRIG_W-1:0] trig_width_r;
  logic [CNT_W-1:0]  timeout_r;
  logic [CNT_W-1:0]  gap_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PING_W-1:0] ping_r, ping_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;

  logic              trig, done, tmo;
  logic [CNT_W-1:0]  cnt_inc;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic [PING_W-1:0] ping_inc;
  phase_t            ph;

  logic              out_valid_r, out_valid_nxt;
  logic              trig_r, busy_r, done_r, tmo_r;
  logic              in_accept;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_TRIG_WIDTH: prdata = 32'(trig_width_r);
      REG_TIMEOUT:    prdata = 32'(timeout_r);
      REG_GAP:        prdata = 32'(gap_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_width_r <= TRIG_WIDTH_RST;
      timeout_r    <= TIMEOUT_RST;
      gap_r        <= GAP_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRIG_WIDTH: trig_width_r <= pwdata[TRIG_W-1:0];
        REG_TIMEOUT:    timeout_r    <= pwdata[CNT_W-1:0];
        REG_GAP:        gap_r        <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall      = out_valid_r && out_stall;
  assign in_accept     = in_valid && !in_stall;
  assign out_valid_nxt = in_accept || (out_valid_r && out_stall);

  // phase logic
  always_comb begin
    ph        = phase_r;
    cnt_nxt   = cnt_r;
    ping_nxt  = ping_r;
    sum_nxt   = sum_r;
    dist_nxt  = dist_r;
    trig      = 1'b0;
    done      = 1'b0;
    tmo       = 1'b0;

    if (ph == PH_IDLE && in_start_request) begin
      ph       = PH_TRIG;
      cnt_nxt  = '0;
      ping_nxt = '0;
      sum_nxt  = '0;
    end

    cnt_inc  = cnt_nxt + 17'd1;
    sum_add  = {1'b0, sum_nxt} + 20'(cnt_nxt);
    sum_sat  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    ping_inc = ping_nxt + 3'd1;
    phase_nxt = ph;

    unique case (ph)
      PH_TRIG: begin
        trig = 1'b1;
        if (cnt_inc >= 17'(trig_width_r)) begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_WAIT: begin
        if (in_echo_level) begin
          if (timeout_r == '0) begin
            phase_nxt = PH_IDLE;
            cnt_nxt   = '0;
            ping_nxt  = '0;
            sum_nxt   = '0;
            dist_nxt  = '0;
            done      = 1'b1;
            tmo       = 1'b1;
          end else begin
            phase_nxt = PH_ECHO;
            cnt_nxt   = 17'd1;
          end
        end
      end
      PH_ECHO: begin
        if (in_echo_level) begin
          if (cnt_nxt >= timeout_r) begin
            phase_nxt = PH_IDLE;
            cnt_nxt   = '0;
            ping_nxt  = '0;
            sum_nxt   = '0;
            dist_nxt  = '0;
            done      = 1'b1;
            tmo       = 1'b1;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end else begin
          cnt_nxt = '0;
          if ({1'b0, ping_inc} >= 4'(PINGS_PER_RUN) || ping_inc == '0) begin
            dist_nxt  = dist_calc(sum_sat);
            phase_nxt = PH_IDLE;
            ping_nxt  = '0;
            sum_nxt   = '0;
            done      = 1'b1;
          end else begin
            ping_nxt  = ping_inc;
            sum_nxt   = sum_sat;
            phase_nxt = (gap_r == '0) ? PH_TRIG : PH_GAP;
          end
        end
      end
      PH_GAP: begin
        if (cnt_inc >= gap_r) begin
          phase_nxt = PH_TRIG;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      ping_r      <= '0;
      sum_r       <= '0;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        ping_r  <= ping_nxt;
        sum_r   <= sum_nxt;
        dist_r  <= dist_nxt;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      trig_r <= trig;
      busy_r <= (phase_nxt != PH_IDLE);
      done_r <= done;
      tmo_r  <= tmo;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_level = trig_r;
  assign out_busy_res      = busy_r;
  assign out_done_res      = done_r;
  assign out_timed_out     = tmo_r;
  assign out_distance_q4   = dist_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done word still marked busy");

  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> out_done_res && out_distance_q4 == '0)
    else $error("timeout word without done or with distance");

  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger_level |-> out_busy_res)
    else $error("trigger driven while idle");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> cnt_r == '0 && ping_r == '0 && sum_r == '0)
    else $error("run state not cleared in idle");

  a_ping_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && phase_r == PH_ECHO |=> {1'b0, ping_r} < 4'(PINGS_PER_RUN))
    else $error("ping index past run length");

endmodule
